/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros used by the frame checker sequencer
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* sv/afc_pkg.sv */
// ---------------------------------------------------------------------------
// afc_pkg
// types, constants and hash helpers for the authenticated frame checker
// ---------------------------------------------------------------------------
`default_nettype none
package afc_pkg;

	localparam int HEADER_BYTES = 12;
	localparam int TAG_BYTES    = 32;
	// header bytes plus the largest body length that can pass the limit check
	localparam int POS_W        = 25;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_W        = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TYPES    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 3'd6;

	// verdict codes
	localparam logic [2:0] VERD_OK      = 3'd0;
	localparam logic [2:0] VERD_LENGTH  = 3'd1;
	localparam logic [2:0] VERD_VERSION = 3'd2;
	localparam logic [2:0] VERD_TYPE    = 3'd3;
	localparam logic [2:0] VERD_REPLAY  = 3'd4;
	localparam logic [2:0] VERD_TAG     = 3'd5;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5c;

	localparam logic [31:0] IV0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// controller states
	typedef enum logic [3:0] {
		S_IDLE, S_IPAD, S_FEED, S_BLK, S_ROUND, S_ADD, S_POST, S_PAD,
		S_OUTLD, S_OPAD, S_TAG, S_FIN, S_EMIT_B, S_EMIT_V, S_EMIT_H, S_HALT
	} state_t;

	// where the frame stands
	typedef enum logic [1:0] {
		PH_HDR, PH_BODY, PH_TAG
	} phase_t;

	// what the running compression is for
	typedef enum logic [2:0] {
		C_IPAD, C_FEED, C_PAD, C_OPAD, C_OUTER
	} ckind_t;

	typedef struct packed {
		logic take;
		logic ld_key;
		logic key_opad;
		logic ld_buf;
		logic round;
		logic hadd;
		logic feed;
		logic hdr_shift;
		logic pad_start;
		logic pad_step;
		logic pad_next_blk;
		logic ld_outer;
		logic tag;
		logic over;
		logic emit;
		logic emit_kind;
	} ctl_cmd_t;

	typedef struct packed {
		logic pos_zero;
		logic hdr_done;
		logic body_last;
		logic len_over;
		logic blen_zero;
		logic fill_last;
		logic rnd_last;
		logic pad_last_blk;
		logic tag_last;
		logic out_free;
	} dp_stat_t;

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

/* sv/afc_dp.sv */
// ---------------------------------------------------------------------------
// afc_dp
// datapath: config registers, block buffer, sha-256 round unit, header,
// tag compare, verdict and output register
// ---------------------------------------------------------------------------
`default_nettype none
module afc_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire afc_pkg::ctl_cmd_t                  cmd,
	output afc_pkg::dp_stat_t                       stat,
	input  wire logic [7:0]                         in_byte,
	input  wire logic                               cfg_we,
	input  wire logic [afc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [afc_pkg::CFG_W-1:0]          cfg_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    item_kind,
	output logic [7:0]                              body_byte,
	output logic [2:0]                              verdict,
	output logic [7:0]                              frame_type,
	output logic [31:0]                             frame_sequence,
	output logic [31:0]                             frame_body_length
);

	// configuration
	logic [63:0] key_q [4];
	logic [7:0]  exp_ver_q;
	logic [55:0] types_q;
	logic [23:0] max_len_q;

	// frame control
	logic [afc_pkg::POS_W-1:0] pos_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [4:0]  tcnt_q;
	logic [7:0]  diff_q;
	logic        pad_first_q;
	logic        lastblk_q;
	logic [2:0]  verdict_q;
	logic [31:0] last_seq_q;
	logic        seen_q;
	logic        out_valid_q;
	logic [95:0] header_q;

	// payload
	logic [7:0]   byte_q;
	logic [511:0] buf_q;
	logic [31:0]  w_q [16];
	logic [31:0]  v_q [8];
	logic [31:0]  h_q [8];

	logic [7:0]   pad_b;
	logic [511:0] key_blk;
	logic [511:0] outer_blk;
	logic [255:0] digest;
	logic [7:0]   tag_b;
	logic [7:0]   diff_d;
	logic [2:0]   verdict_d;
	logic [31:0]  blen;
	logic [31:0]  seq;
	logic [afc_pkg::POS_W-1:0] msglen;
	logic [63:0]  len_bits;
	logic [7:0]   len_b;
	logic [7:0]   pad_byte;
	logic         type_ok;
	logic [31:0]  t1, t2, w_new;

	assign blen   = header_q[31:0];
	assign seq    = header_q[63:32];
	assign msglen = afc_pkg::POS_W'(afc_pkg::HEADER_BYTES) + {1'b0, blen[23:0]};

	// hmac key blocks
	assign pad_b   = cmd.key_opad ? afc_pkg::OPAD_BYTE : afc_pkg::IPAD_BYTE;
	assign key_blk = {({key_q[0], key_q[1], key_q[2], key_q[3]} ^ {32{pad_b}}), {32{pad_b}}};

	assign digest    = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
	assign outer_blk = {digest, 8'h80, 184'd0, 64'd768};

	// padding byte: marker, zeros, then the bit length in the last eight places
	assign len_bits = {35'd0, ({1'b0, pos_q} + 26'd64), 3'd0};
	assign len_b    = len_bits[{3'(3'd7 - fill_q[2:0]), 3'b000} +: 8];
	always_comb begin
		if (pad_first_q) begin
			pad_byte = 8'h80;
		end else if (lastblk_q && (fill_q[5:3] == 3'b111)) begin
			pad_byte = len_b;
		end else begin
			pad_byte = 8'h00;
		end
	end

	// round function
	always_comb begin
		t1 = v_q[7] + afc_pkg::big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ afc_pkg::ROUND_K[rnd_q] + w_q[0];
		t2 = afc_pkg::big_sigma0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = w_q[0] + afc_pkg::small_sigma0(w_q[1]) + w_q[9] + afc_pkg::small_sigma1(w_q[14]);
	end

	// tag byte compare and verdict
	assign tag_b  = digest[{~tcnt_q, 3'b000} +: 8];
	assign diff_d = diff_q | (byte_q ^ tag_b);

	always_comb begin
		type_ok = 1'b0;
		for (int k = 0; k < 7; k++) begin
			if (types_q[8*k +: 8] == header_q[87:80]) begin
				type_ok = 1'b1;
			end
		end
	end

	always_comb begin
		priority if (header_q[95:88] != exp_ver_q) begin
			verdict_d = afc_pkg::VERD_VERSION;
		end else if (!type_ok) begin
			verdict_d = afc_pkg::VERD_TYPE;
		end else if (seen_q && (seq <= last_seq_q)) begin
			verdict_d = afc_pkg::VERD_REPLAY;
		end else if (diff_d != 8'd0) begin
			verdict_d = afc_pkg::VERD_TAG;
		end else begin
			verdict_d = afc_pkg::VERD_OK;
		end
	end

	// status to the controller
	always_comb begin
		stat.pos_zero     = (pos_q == '0);
		stat.hdr_done     = (pos_q == afc_pkg::POS_W'(afc_pkg::HEADER_BYTES));
		stat.body_last    = (pos_q == msglen);
		stat.len_over     = (blen > {8'd0, max_len_q});
		stat.blen_zero    = (blen == 32'd0);
		stat.fill_last    = (fill_q == 6'd63);
		stat.rnd_last     = (rnd_q == 6'd63);
		stat.pad_last_blk = lastblk_q;
		stat.tag_last     = (tcnt_q == 5'(afc_pkg::TAG_BYTES - 1));
		stat.out_free     = !out_valid_q || out_ready;
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			exp_ver_q   <= 8'd1;
			types_q     <= '0;
			max_len_q   <= 24'd65536;
			pos_q       <= '0;
			fill_q      <= '0;
			rnd_q       <= '0;
			tcnt_q      <= '0;
			diff_q      <= '0;
			pad_first_q <= 1'b0;
			lastblk_q   <= 1'b0;
			verdict_q   <= afc_pkg::VERD_OK;
			last_seq_q  <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
			header_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					afc_pkg::REG_KEY0, afc_pkg::REG_KEY1,
					afc_pkg::REG_KEY2, afc_pkg::REG_KEY3: begin
						key_q[cfg_index[1:0]] <= cfg_data;
					end
					afc_pkg::REG_VERSION: begin
						exp_ver_q <= cfg_data[7:0];
					end
					afc_pkg::REG_TYPES: begin
						types_q <= cfg_data[55:0];
					end
					afc_pkg::REG_MAX_LEN: begin
						max_len_q <= cfg_data[23:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.tag && stat.tag_last) begin
				pos_q <= '0;
			end else if (cmd.feed) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.ld_key && !cmd.key_opad) begin
				fill_q <= '0;
			end else if (cmd.feed || cmd.pad_step) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.ld_key || cmd.ld_buf) begin
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (cmd.pad_start) begin
				pad_first_q <= 1'b1;
				lastblk_q   <= (fill_q < 6'd56);
			end else begin
				if (cmd.pad_step) begin
					pad_first_q <= 1'b0;
				end
				if (cmd.pad_next_blk) begin
					lastblk_q <= 1'b1;
				end
			end
			// tag bytes and the verdict at the last one
			if (cmd.tag) begin
				tcnt_q <= tcnt_q + 1'b1;
				diff_q <= stat.tag_last ? 8'd0 : diff_d;
				if (stat.tag_last) begin
					verdict_q <= verdict_d;
					if (verdict_d == afc_pkg::VERD_OK) begin
						last_seq_q <= seq;
						seen_q     <= 1'b1;
					end
				end
			end
			if (cmd.over) begin
				verdict_q <= afc_pkg::VERD_LENGTH;
			end
			if (cmd.feed && cmd.hdr_shift) begin
				header_q <= {header_q[87:0], byte_q};
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: byte, buffer, schedule, working and chaining values, output fields
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= in_byte;
		end
		if (cmd.feed) begin
			buf_q <= {buf_q[503:0], byte_q};
		end else if (cmd.pad_step) begin
			buf_q <= {buf_q[503:0], pad_byte};
		end else if (cmd.ld_outer) begin
			buf_q <= outer_blk;
		end
		if (cmd.ld_key) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= key_blk[511 - 32*i -: 32];
			end
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= afc_pkg::IV0[i];
				v_q[i] <= afc_pkg::IV0[i];
			end
		end else if (cmd.ld_buf) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= buf_q[511 - 32*i -: 32];
			end
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q[0]  <= t1 + t2;
			v_q[1]  <= v_q[0];
			v_q[2]  <= v_q[1];
			v_q[3]  <= v_q[2];
			v_q[4]  <= v_q[3] + t1;
			v_q[5]  <= v_q[4];
			v_q[6]  <= v_q[5];
			v_q[7]  <= v_q[6];
		end else if (cmd.hadd) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end
		if (cmd.emit) begin
			item_kind         <= cmd.emit_kind;
			body_byte         <= cmd.emit_kind ? 8'd0 : byte_q;
			verdict           <= cmd.emit_kind ? verdict_q : afc_pkg::VERD_OK;
			frame_type        <= header_q[87:80];
			frame_sequence    <= seq;
			frame_body_length <= blen;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* sv/afc_ctrl.sv */
// ---------------------------------------------------------------------------
// afc_ctrl
// sequencer: walks each byte through feed, compression, padding,
// outer hash, tag compare and result hand-off
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module afc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire afc_pkg::dp_stat_t   stat,
	output afc_pkg::ctl_cmd_t        cmd
);

	afc_pkg::state_t state_q, state_d;
	afc_pkg::phase_t phase_q, phase_d;
	afc_pkg::ckind_t ckind_q, ckind_d;

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		ckind_d = ckind_q;
		unique case (state_q)
			afc_pkg::S_IDLE: begin
				if (in_valid) begin
					if (phase_q == afc_pkg::PH_TAG) begin
						state_d = afc_pkg::S_TAG;
					end else if (stat.pos_zero) begin
						state_d = afc_pkg::S_IPAD;
					end else begin
						state_d = afc_pkg::S_FEED;
					end
				end
			end
			afc_pkg::S_IPAD: begin
				ckind_d = afc_pkg::C_IPAD;
				state_d = afc_pkg::S_ROUND;
			end
			afc_pkg::S_FEED: begin
				if (stat.fill_last) begin
					ckind_d = afc_pkg::C_FEED;
					state_d = afc_pkg::S_BLK;
				end else begin
					state_d = afc_pkg::S_POST;
				end
			end
			afc_pkg::S_BLK: begin
				state_d = afc_pkg::S_ROUND;
			end
			afc_pkg::S_ROUND: begin
				if (stat.rnd_last) begin
					state_d = afc_pkg::S_ADD;
				end
			end
			afc_pkg::S_ADD: begin
				unique case (ckind_q)
					afc_pkg::C_IPAD:  state_d = afc_pkg::S_FEED;
					afc_pkg::C_FEED:  state_d = afc_pkg::S_POST;
					afc_pkg::C_PAD:   state_d = stat.pad_last_blk ? afc_pkg::S_OUTLD
						: afc_pkg::S_PAD;
					afc_pkg::C_OPAD: begin
						ckind_d = afc_pkg::C_OUTER;
						state_d = afc_pkg::S_BLK;
					end
					afc_pkg::C_OUTER: state_d = afc_pkg::S_FIN;
					default:          state_d = afc_pkg::S_IDLE;
				endcase
			end
			afc_pkg::S_POST: begin
				if (phase_q == afc_pkg::PH_HDR) begin
					if (!stat.hdr_done) begin
						state_d = afc_pkg::S_IDLE;
					end else if (stat.len_over) begin
						state_d = afc_pkg::S_EMIT_H;
					end else if (stat.blen_zero) begin
						state_d = afc_pkg::S_PAD;
					end else begin
						phase_d = afc_pkg::PH_BODY;
						state_d = afc_pkg::S_IDLE;
					end
				end else if (stat.body_last) begin
					state_d = afc_pkg::S_PAD;
				end else begin
					state_d = afc_pkg::S_EMIT_B;
				end
			end
			afc_pkg::S_PAD: begin
				if (stat.fill_last) begin
					ckind_d = afc_pkg::C_PAD;
					state_d = afc_pkg::S_BLK;
				end
			end
			afc_pkg::S_OUTLD: begin
				state_d = afc_pkg::S_OPAD;
			end
			afc_pkg::S_OPAD: begin
				ckind_d = afc_pkg::C_OPAD;
				state_d = afc_pkg::S_ROUND;
			end
			afc_pkg::S_FIN: begin
				phase_d = afc_pkg::PH_TAG;
				state_d = (phase_q == afc_pkg::PH_BODY) ? afc_pkg::S_EMIT_B
					: afc_pkg::S_IDLE;
			end
			afc_pkg::S_TAG: begin
				if (stat.tag_last) begin
					phase_d = afc_pkg::PH_HDR;
					state_d = afc_pkg::S_EMIT_V;
				end else begin
					state_d = afc_pkg::S_IDLE;
				end
			end
			afc_pkg::S_EMIT_B, afc_pkg::S_EMIT_V: begin
				if (stat.out_free) begin
					state_d = afc_pkg::S_IDLE;
				end
			end
			afc_pkg::S_EMIT_H: begin
				if (stat.out_free) begin
					state_d = afc_pkg::S_HALT;
				end
			end
			afc_pkg::S_HALT: begin
				state_d = afc_pkg::S_HALT;
			end
			default: begin
				state_d = afc_pkg::S_IDLE;
			end
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			afc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			afc_pkg::S_IPAD: begin
				cmd.ld_key = 1'b1;
			end
			afc_pkg::S_OPAD: begin
				cmd.ld_key   = 1'b1;
				cmd.key_opad = 1'b1;
			end
			afc_pkg::S_FEED: begin
				cmd.feed      = 1'b1;
				cmd.hdr_shift = (phase_q == afc_pkg::PH_HDR);
			end
			afc_pkg::S_BLK: begin
				cmd.ld_buf = 1'b1;
			end
			afc_pkg::S_ROUND: begin
				cmd.round = 1'b1;
			end
			afc_pkg::S_ADD: begin
				cmd.hadd         = 1'b1;
				cmd.pad_next_blk = (ckind_q == afc_pkg::C_PAD) && !stat.pad_last_blk;
			end
			afc_pkg::S_POST: begin
				if (phase_q == afc_pkg::PH_HDR) begin
					cmd.over      = stat.hdr_done && stat.len_over;
					cmd.pad_start = stat.hdr_done && !stat.len_over && stat.blen_zero;
				end else begin
					cmd.pad_start = stat.body_last;
				end
			end
			afc_pkg::S_PAD: begin
				cmd.pad_step = 1'b1;
			end
			afc_pkg::S_OUTLD: begin
				cmd.ld_outer = 1'b1;
			end
			afc_pkg::S_TAG: begin
				cmd.tag = 1'b1;
			end
			afc_pkg::S_EMIT_B: begin
				cmd.emit = stat.out_free;
			end
			afc_pkg::S_EMIT_V, afc_pkg::S_EMIT_H: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = 1'b1;
			end
			// halted stream: every later transfer is taken and dropped
			afc_pkg::S_HALT: begin
				in_ready = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= afc_pkg::S_IDLE;
			phase_q <= afc_pkg::PH_HDR;
			ckind_q <= afc_pkg::C_IPAD;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			ckind_q <= ckind_d;
		end
	end

	`ASSERT_AT(a_one_byte_at_a_time, clk, arst_n, (in_valid && in_ready && (state_q == afc_pkg::S_IDLE)) |=> !in_ready)
	`ASSERT_AT(a_halt_sticky, clk, arst_n, (state_q == afc_pkg::S_HALT) |=> (state_q == afc_pkg::S_HALT))
	`ASSERT_AT(a_emit_slot_free, clk, arst_n, cmd.emit |-> stat.out_free)
	`ASSERT_AT(a_rounds_then_add, clk, arst_n, (cmd.round && stat.rnd_last) |=> cmd.hadd)
	`ASSERT_NEVER(a_no_pad_in_tag, clk, arst_n, cmd.pad_step && (phase_q == afc_pkg::PH_TAG))

endmodule
`default_nettype wire

/* sv/authenticated_frame_checker_core.sv */
// Header bytes go through feed, tag bytes through tag compare; the last tag byte also hands
// off the verdict and body bytes the result; the first byte of a frame adds the keyed inner
// block compression and a byte that completes a 64-byte block adds another compression.
// Frame end adds padding and three or four compressions.
// The byte-serial sequencer and round unit take no new byte until done with the last one.
// Reset is asynchronous and clears control and configuration at once; no clearing pass.
// ---------------------------------------------------------------------------
// authenticated_frame_checker_core
// checks hmac-sha256 tagged frames on a byte stream and passes body bytes on
// ---------------------------------------------------------------------------
`default_nettype none
module authenticated_frame_checker_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     in_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                item_kind,
	output logic [7:0]                          body_byte,
	output logic [2:0]                          verdict,
	output logic [7:0]                          frame_type,
	output logic [31:0]                         frame_sequence,
	output logic [31:0]                         frame_body_length,
	input  wire logic                           cfg_we,
	input  wire logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [afc_pkg::CFG_W-1:0]      cfg_data
);

	afc_pkg::ctl_cmd_t cmd;
	afc_pkg::dp_stat_t stat;

	// sequencer
	afc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// hash and check datapath
	afc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_byte           (in_byte),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.item_kind         (item_kind),
		.body_byte         (body_byte),
		.verdict           (verdict),
		.frame_type        (frame_type),
		.frame_sequence    (frame_sequence),
		.frame_body_length (frame_body_length)
	);

endmodule
`default_nettype wire
